// ===== rtl/stkpp_pkg.sv =====
// Shared constants and types for the spectrum top-K peak picker.
`default_nettype none

package stkpp_pkg;

   // Frame and field geometry.
   localparam int MAX_BINS   = 1024;
   localparam int AMP_BITS   = 16;
   localparam int TOP_K      = 3;
   localparam int BIN_BITS   = $clog2(MAX_BINS);
   localparam int RANK_BITS  = 2;
   localparam int SLOT_BITS  = $clog2(TOP_K + 1);
   localparam int RATIO_BITS = 16;
   localparam int CMP_BITS   = AMP_BITS + RATIO_BITS;

   // Stream word widths, padded to whole bytes.
   localparam int REQ_DATA_BITS  = ((AMP_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = RANK_BITS + BIN_BITS + AMP_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(66);

   // One entry of the sorted peak list.
   typedef struct packed {
      logic                valid;
      logic [AMP_BITS-1:0] amp;
      logic [BIN_BITS-1:0] bin;
   } slot_type;

   // Peak candidate offered to the whole cell row.
   typedef struct packed {
      logic                insert;
      logic [AMP_BITS-1:0] amp;
      logic [BIN_BITS-1:0] bin;
   } cand_type;

endpackage

`default_nettype wire

// ===== rtl/stkpp_cell.sv =====
// One cell of the sorted peak list: holds a slot and shifts it to its neighbor.
`default_nettype none

module stkpp_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  stkpp_pkg::cand_type cand,
   input  stkpp_pkg::slot_type up_slot,
   input  logic                up_beat,
   output stkpp_pkg::slot_type slot,
   output stkpp_pkg::slot_type merged,
   output logic                beat
);
   import stkpp_pkg::*;

   slot_type slot_ff;
   slot_type slot_in;

   // The candidate beats this slot when the slot is empty or strictly weaker.
   assign beat = cand.insert && (!slot_ff.valid || (cand.amp > slot_ff.amp));

   // If the upstream cell was beaten, its entry moves down into this one.
   always_comb begin
      if (up_beat) begin
         merged = up_slot;
      end else if (beat) begin
         merged = '{valid: 1'b1, amp: cand.amp, bin: cand.bin};
      end else begin
         merged = slot_ff;
      end
      slot_in = clear ? '0 : merged;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot = slot_ff;

endmodule

`default_nettype wire

// ===== rtl/stkpp_report.sv =====
// Frame report unit: holds a finished peak list and streams the qualifying peaks.
`default_nettype none

module stkpp_report (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  stkpp_pkg::slot_type                   snap_slots [stkpp_pkg::TOP_K],
   input  logic [stkpp_pkg::AMP_BITS-1:0]        snap_max,
   input  logic [stkpp_pkg::RATIO_BITS-1:0]      ratio,
   output logic                                  busy,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [stkpp_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                  rsp_tlast
);
   import stkpp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_DRAIN
   } state_type;

   state_type                  state_ff;
   slot_type                   slots_ff [TOP_K];
   logic [AMP_BITS-1:0]        max_ff;
   logic [CMP_BITS-1:0]        prod_ff;
   logic [SLOT_BITS-1:0]       idx_ff;
   logic                       rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0]   rsp_data_ff;
   logic                       rsp_last_ff;

   logic [TOP_K:0]             pass_vec;
   logic [SLOT_BITS-1:0]       next_idx;
   logic                       last_pick;
   logic                       out_free;
   logic                       emit;
   slot_type                   pick;

   // A peak passes when amp * 2^16 exceeds ratio * frame maximum.
   for (genvar k = 0; k < TOP_K; k++) begin : g_pass
      assign pass_vec[k] = slots_ff[k].valid &&
                           ({slots_ff[k].amp, {RATIO_BITS{1'b0}}} > prod_ff);
   end
   assign pass_vec[TOP_K] = 1'b0;

   assign next_idx  = idx_ff + SLOT_BITS'(1);
   assign last_pick = !pass_vec[next_idx];
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign pick      = slots_ff[idx_ff];

   // A new result word is loaded into the output register this cycle.
   assign emit = (state_ff == ST_DRAIN) && pass_vec[idx_ff] && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (load) begin
                  slots_ff <= snap_slots;
                  max_ff   <= snap_max;
                  state_ff <= ST_MULT;
               end
            end
            ST_MULT: begin
               prod_ff  <= CMP_BITS'(ratio) * CMP_BITS'(max_ff);
               idx_ff   <= '0;
               state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               if (!pass_vec[idx_ff]) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  rsp_data_ff  <= RSP_DATA_BITS'({pick.amp, pick.bin, RANK_BITS'(idx_ff)});
                  rsp_last_ff  <= last_pick;
                  if (last_pick) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff <= next_idx;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/spectrum_top_k_peak_picker_unit.sv =====
// Top level of the spectrum top-K peak picker.
`default_nettype none

// The block takes one spectrum frame as a stream of amplitude words, one bin
// per word, with tlast on the final bin, and counts the bin index itself.
// Every bin that is at least its left neighbor and strictly above its right
// neighbor (first and last bins excluded) is a peak; the three strongest are
// kept in a row of three cells that forms a sorted list, earlier peaks winning
// ties. After the final bin the finished list moves to a report unit, which
// sends, strongest first, each kept peak whose amplitude times 2^16 exceeds
// threshold_ratio times the frame maximum (maximum taken over bins 1 onward).
// A frame yields zero to three result words, the last one flagged by tlast.
// Input rate is one bin per cycle, and the frame's list and counters are
// cleared the moment its final bin is taken, so the next frame follows at
// once. The only stall is on a final bin that arrives while the report unit
// still works on the previous frame: it forms the threshold product and then
// sends each passing peak, and waits while the result side holds tready low.
// The first result word is registered after the list is loaded into the
// report unit and its threshold product is registered.
// The threshold register may be written at any time the block is idle.

module spectrum_top_k_peak_picker_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Bin stream. tdata: amplitude[15:0]. tlast: last_bin.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [stkpp_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                                req_tlast,
   // Peak stream. tdata: rank[1:0], peak_bin[11:2], peak_amplitude[27:12],
   // zero padding[31:28]. tlast: last.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [stkpp_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                                rsp_tlast,
   // Threshold register write: threshold_ratio as a Q0.16 fraction.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [stkpp_pkg::RATIO_BITS-1:0]    csr_data
);
   import stkpp_pkg::*;

   logic [RATIO_BITS-1:0] ratio_ff;
   logic [BIN_BITS-1:0]   bin_cnt_ff;
   logic [AMP_BITS-1:0]   older_ff;
   logic [AMP_BITS-1:0]   newer_ff;
   logic [AMP_BITS-1:0]   max_ff;

   logic [AMP_BITS-1:0]   amp;
   logic                  accept;
   logic                  frame_end;
   logic                  past_first;
   logic                  past_second;
   logic                  is_peak;
   logic [AMP_BITS-1:0]   max_in;
   logic                  report_busy;
   cand_type              cand;

   slot_type              cell_slot   [TOP_K];
   slot_type              cell_merged [TOP_K];
   logic                  cell_beat   [TOP_K];

   // Configuration port: always ready, one register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= RATIO_RESET;
      end else if (csr_valid) begin
         ratio_ff <= csr_data;
      end
   end

   // A final bin waits only while the previous frame is still being reported.
   assign req_tready = !(report_busy && req_tlast);
   assign accept     = req_tvalid && req_tready;
   assign frame_end  = accept && req_tlast;
   assign amp        = req_tdata[AMP_BITS-1:0];

   assign past_first  = (bin_cnt_ff != '0);
   assign past_second = (bin_cnt_ff >= BIN_BITS'(2));

   // The previous bin becomes a peak once its right neighbor is seen.
   assign is_peak = past_second && (newer_ff >= older_ff) && (newer_ff > amp);

   assign cand.insert = accept && is_peak;
   assign cand.amp    = newer_ff;
   assign cand.bin    = bin_cnt_ff - BIN_BITS'(1);

   assign max_in = (past_first && (amp > max_ff)) ? amp : max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_cnt_ff <= '0;
         older_ff   <= '0;
         newer_ff   <= '0;
         max_ff     <= '0;
      end else if (accept) begin
         if (req_tlast) begin
            bin_cnt_ff <= '0;
            older_ff   <= '0;
            newer_ff   <= '0;
            max_ff     <= '0;
         end else begin
            // The bin index saturates on an overlong frame.
            if (bin_cnt_ff != BIN_BITS'(MAX_BINS - 1)) begin
               bin_cnt_ff <= bin_cnt_ff + BIN_BITS'(1);
            end
            older_ff <= newer_ff;
            newer_ff <= amp;
            max_ff   <= max_in;
         end
      end
   end

   // Row of list cells, strongest entry in cell 0. Each cell sees the
   // candidate and, when its upper neighbor is displaced, takes that entry.
   for (genvar k = 0; k < TOP_K; k++) begin : g_cell
      slot_type up_slot;
      logic     up_beat;

      if (k == 0) begin : g_head
         assign up_slot = '0;
         assign up_beat = 1'b0;
      end else begin : g_link
         assign up_slot = cell_slot[k-1];
         assign up_beat = cell_beat[k-1];
      end

      stkpp_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .clear   (frame_end),
         .cand    (cand),
         .up_slot (up_slot),
         .up_beat (up_beat),
         .slot    (cell_slot[k]),
         .merged  (cell_merged[k]),
         .beat    (cell_beat[k])
      );
   end

   // The list including the final bin's peak goes to the report unit.
   stkpp_report u_report (
      .clock      (clock),
      .reset      (reset),
      .load       (frame_end),
      .snap_slots (cell_merged),
      .snap_max   (max_in),
      .ratio      (ratio_ff),
      .busy       (report_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/stkpp_checker.sv =====
// Port-level checks for the peak picker, bound to its top level.
`default_nettype none

module stkpp_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [stkpp_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                                rsp_tlast
);
   import stkpp_pkg::*;

   // A stalled result word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // Ranks never reach beyond the list depth.
   a_rank_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RANK_BITS-1:0] < RANK_BITS'(TOP_K)))
      else $error("rank out of range");

   // Within a frame the next result follows at once with the next rank.
   a_rank_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid &&
         (rsp_tdata[RANK_BITS-1:0] == $past(rsp_tdata[RANK_BITS-1:0]) + RANK_BITS'(1)))
      else $error("rank sequence broken");

endmodule

bind spectrum_top_k_peak_picker_unit stkpp_checker u_stkpp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the spectrum top-K peak picker: directed and random frames.

// The testbench streams spectrum frames into the peak picker, one bin per
// word, and checks every peak word that comes back against a predictor that
// keeps its own copy of the frame state and the threshold register.
//
// The run has a short directed part and then six random phases:
//  - The directed part covers one-bin and two-bin frames, full-scale
//    amplitudes, and plateaus and ties. It also covers more than three peaks
//    in one frame, a peak that falls under the threshold, and a high first
//    bin that must never count as a peak. Rows whose outcome is obvious carry
//    a typed expectation. All other rows go through the predictor.
//  - Each random phase first lets the block go idle. It then writes a new
//    threshold and streams random frames of varied shape. Zero, full scale
//    and random thresholds are all visited.
//  - The sender and the receiver idle at random. First the sender idles
//    rarely and the receiver often, then the other way round, and in the last
//    two phases neither side idles.
// Result words are compared field by field in order. A watchdog ends the run
// if no word moves on any channel for too long.

module tb;
   import stkpp_pkg::*;

   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_BINS   = 75;

   // How a directed row is checked: through the predictor, or against a
   // typed expectation of no peak word or of exactly one peak word.
   typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_ONE} row_check_type;

   // Amplitude shapes of random frames.
   typedef enum logic [1:0] {SHAPE_WIDE, SHAPE_TIES, SHAPE_TOP, SHAPE_SPARSE} frame_shape_type;

   typedef struct {
      logic [AMP_BITS-1:0] amp;
      logic                last_bin;
      row_check_type       check;
      logic [BIN_BITS-1:0] peak_bin;
      logic [AMP_BITS-1:0] peak_amp;
   } bin_row_type;

   typedef struct {
      logic [RANK_BITS-1:0] rank;
      logic [BIN_BITS-1:0]  peak_bin;
      logic [AMP_BITS-1:0]  peak_amp;
      logic                 last;
   } peak_word_type;

   // Directed frames, each closed by a row with last_bin set.
   bin_row_type directed_bins [25] = '{
      // A one-bin frame has no candidates at all.
      '{16'hFFFF, 1'b1, CHECK_NONE,  10'd0, 16'h0000},
      // A two-bin frame has no candidates either.
      '{16'h0005, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'h0009, 1'b1, CHECK_NONE,  10'd0, 16'h0000},
      // A single full-scale peak between two zero bins.
      '{16'h0000, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'hFFFF, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'h0000, 1'b1, CHECK_ONE,   10'd1, 16'hFFFF},
      // A plateau, four peaks with a tie for third place, and a flat tail.
      '{16'h0001, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'h0007, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'h0007, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'h0003, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'h0009, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'h0002, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'h0007, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'h0001, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'h0008, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'h0000, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'h0000, 1'b1, CHECK_MODEL, 10'd0, 16'h0000},
      // A tiny peak next to a full-scale one falls under the default threshold.
      '{16'h0000, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'hFFFF, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'h0000, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'h0001, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'h0000, 1'b1, CHECK_MODEL, 10'd0, 16'h0000},
      // The first bin is the highest, but it is never a peak.
      '{16'h0009, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'h0001, 1'b0, CHECK_MODEL, 10'd0, 16'h0000},
      '{16'h0000, 1'b1, CHECK_NONE,  10'd0, 16'h0000}
   };

   // Idle rates in percent for the three idling modes.
   int send_idle_by_mode  [3] = '{9, 63, 0};
   int rsp_stall_by_mode  [3] = '{63, 9, 0};
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     req_tlast  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [RATIO_BITS-1:0]    csr_data   = '0;

   // Predictor state: threshold register, bin counter, the two previous bins,
   // the frame maximum, and the sorted list of kept peaks.
   logic [RATIO_BITS-1:0] model_ratio    = RATIO_RESET;
   logic [BIN_BITS-1:0]   model_next_bin = '0;
   logic [AMP_BITS-1:0]   model_older    = '0;
   logic [AMP_BITS-1:0]   model_newer    = '0;
   logic [AMP_BITS-1:0]   model_max      = '0;
   slot_type              model_list [TOP_K] = '{default: '0};

   peak_word_type expected_peaks [$];
   peak_word_type oldest_peak;
   int            mismatch_count = 0;
   int            quiet_cycles   = 0;

   spectrum_top_k_peak_picker_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   task automatic flag_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Advances the predictor by one accepted bin.
   // On the final bin of a frame it works out the peak words that pass the
   // threshold and queues them if publish is set. It then clears the frame.
   function automatic void predict_bin(input logic [AMP_BITS-1:0] amp,
                                       input logic last_bin, input bit publish);
      logic [BIN_BITS-1:0] idx;
      logic [CMP_BITS-1:0] scaled_peak;
      logic [CMP_BITS-1:0] scaled_max;
      peak_word_type       word;
      peak_word_type       found [$];
      bit                  placed;
      idx    = model_next_bin;
      placed = 1'b0;
      if (idx >= 1 && amp > model_max) begin
         model_max = amp;
      end
      // The previous bin can be judged once its right neighbor is known.
      // It goes in before the first kept peak that it strictly beats, so ties
      // favor the earlier peak.
      if (idx >= 2 && model_newer >= model_older && model_newer > amp) begin
         for (int s = 0; s < TOP_K; s++) begin
            if (!placed && (!model_list[s].valid || model_newer > model_list[s].amp)) begin
               for (int k = TOP_K - 1; k > s; k--) begin
                  model_list[k] = model_list[k-1];
               end
               model_list[s] = '{valid: 1'b1, amp: model_newer, bin: idx - 1'b1};
               placed = 1'b1;
            end
         end
      end
      model_older = model_newer;
      model_newer = amp;
      if (model_next_bin < BIN_BITS'(MAX_BINS - 1)) begin
         model_next_bin++;
      end
      if (last_bin) begin
         scaled_max = model_ratio * model_max;
         for (int s = 0; s < TOP_K; s++) begin
            scaled_peak = CMP_BITS'(model_list[s].amp) << RATIO_BITS;
            if (model_list[s].valid && scaled_peak > scaled_max) begin
               word.rank     = RANK_BITS'(s);
               word.peak_bin = model_list[s].bin;
               word.peak_amp = model_list[s].amp;
               word.last     = 1'b0;
               found.push_back(word);
            end
         end
         if (found.size() > 0) begin
            found[found.size()-1].last = 1'b1;
         end
         if (publish) begin
            foreach (found[i]) begin
               expected_peaks.push_back(found[i]);
            end
         end
         model_next_bin = '0;
         model_older    = '0;
         model_newer    = '0;
         model_max      = '0;
         foreach (model_list[s]) begin
            model_list[s] = '0;
         end
      end
   endfunction

   // Offers one bin word, possibly after a random gap, and waits until it is
   // accepted. Valid stays high into the next word unless a gap follows.
   task automatic push_bin(input logic [AMP_BITS-1:0] amp, input logic last_bin,
                           input bit publish);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'(amp);
      req_tlast  <= last_bin;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      predict_bin(amp, last_bin, publish);
   endtask

   // Waits until every expected peak word is back.
   // A frame that reports nothing can still keep the report unit busy for its
   // threshold product, so a few more cycles pass after that.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_peaks.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_ratio(input logic [RATIO_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid   <= 1'b0;
      model_ratio  = value;
   endtask

   // Streams random frames of random length and shape until about budget
   // bins have gone in.
   task automatic send_random_frames(input int budget);
      int                  sent;
      int                  len;
      frame_shape_type     shape;
      logic [AMP_BITS-1:0] amp;
      sent = 0;
      while (sent < budget) begin
         len   = ($urandom_range(99) < 12) ? $urandom_range(2, 1) : $urandom_range(24, 3);
         shape = frame_shape_type'($urandom_range(3));
         for (int k = 0; k < len; k++) begin
            case (shape)
               SHAPE_WIDE: begin
                  amp = AMP_BITS'($urandom);
               end
               SHAPE_TIES: begin
                  amp = AMP_BITS'($urandom_range(3));
               end
               SHAPE_TOP: begin
                  amp = AMP_BITS'($urandom_range(16'hFFFF, 16'hFFF8));
               end
               default: begin
                  amp = ($urandom_range(3) == 0) ? '0 : AMP_BITS'($urandom_range(4095));
               end
            endcase
            push_bin(amp, k == len - 1, 1'b1);
         end
         sent += len;
      end
   endtask

   // The receiver stalls at random, at the rate of the current mode.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Every peak word taken by the receiver is compared with the oldest
   // expectation, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_peaks.size() == 0) begin
            flag_mismatch($sformatf("peak word %h with nothing expected", rsp_tdata));
         end else begin
            oldest_peak = expected_peaks.pop_front();
            if (rsp_tdata[0 +: RANK_BITS] != oldest_peak.rank) begin
               flag_mismatch($sformatf("rank %0d, expected %0d",
                                       rsp_tdata[0 +: RANK_BITS], oldest_peak.rank));
            end
            if (rsp_tdata[RANK_BITS +: BIN_BITS] != oldest_peak.peak_bin) begin
               flag_mismatch($sformatf("peak_bin %0d, expected %0d",
                                       rsp_tdata[RANK_BITS +: BIN_BITS],
                                       oldest_peak.peak_bin));
            end
            if (rsp_tdata[RANK_BITS+BIN_BITS +: AMP_BITS] != oldest_peak.peak_amp) begin
               flag_mismatch($sformatf("peak_amplitude %h, expected %h",
                                       rsp_tdata[RANK_BITS+BIN_BITS +: AMP_BITS],
                                       oldest_peak.peak_amp));
            end
            if (rsp_tlast !== oldest_peak.last) begin
               flag_mismatch($sformatf("tlast %b, expected %b", rsp_tlast, oldest_peak.last));
            end
         end
      end
   end

   // The watchdog counts cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("spectrum_top_k_peak_picker_unit test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      peak_word_type typed_peak;
      logic [RATIO_BITS-1:0] ratio;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The directed part runs at the reset threshold.
      send_idle_pct = send_idle_by_mode[0];
      rsp_stall_pct = rsp_stall_by_mode[0];
      foreach (directed_bins[i]) begin
         push_bin(directed_bins[i].amp, directed_bins[i].last_bin,
                  directed_bins[i].check == CHECK_MODEL);
         if (directed_bins[i].check == CHECK_ONE) begin
            typed_peak.rank     = '0;
            typed_peak.peak_bin = directed_bins[i].peak_bin;
            typed_peak.peak_amp = directed_bins[i].peak_amp;
            typed_peak.last     = 1'b1;
            expected_peaks.push_back(typed_peak);
         end
      end

      // The random phases. Two phases run in each idling mode, and each
      // phase starts with a threshold write while the block is idle.
      for (int phase = 0; phase < 6; phase++) begin
         drain_results();
         send_idle_pct = send_idle_by_mode[phase / 2];
         rsp_stall_pct = rsp_stall_by_mode[phase / 2];
         case (phase)
            0:       ratio = '0;
            1:       ratio = '1;
            3:       ratio = RATIO_BITS'($urandom_range(512, 1));
            default: ratio = RATIO_BITS'($urandom);
         endcase
         write_ratio(ratio);
         send_random_frames(PHASE_BINS);
      end

      drain_results();
      if (mismatch_count == 0) begin
         $display("spectrum_top_k_peak_picker_unit test passed");
      end else begin
         $display("spectrum_top_k_peak_picker_unit test failed");
      end
      $finish;
   end

endmodule
